### sv/mesh_vertex_normal_accumulator_assert.svh
// assertion macros used by the checker file
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define MVNA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mvna assertion failed");

// next-cycle implication, disabled while reset is high
`define MVNA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mvna assertion failed");

`endif

### sv/mvna_pkg.sv
`timescale 1ns / 1ps
package mvna_pkg;

   localparam int IDX_W  = 12;
   localparam int VCNT_W = 13;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam int SQRT_STEPS = 32;

   // configuration register indexes (paddr bit 2)
   localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;
   localparam logic [0:0] REG_INVERT_MODE  = 1'b1;

   typedef enum logic [1:0] {
      CMD_WRITE    = 2'd0,
      CMD_TRIANGLE = 2'd1,
      CMD_READ     = 2'd2,
      CMD_CLEAR    = 2'd3
   } cmd_type;

   // lane codes: triangle corners and normal components
   localparam logic [1:0] LANE_0 = 2'd0;
   localparam logic [1:0] LANE_1 = 2'd1;
   localparam logic [1:0] LANE_2 = 2'd2;

   // vertex read select
   localparam logic [1:0] VSEL_A = 2'd0;
   localparam logic [1:0] VSEL_B = 2'd1;

   typedef struct packed {
      logic       load;
      logic       decode;
      logic       vwrite;
      logic [1:0] vsel;
      logic       cap_a;
      logic       cap_b;
      logic       cap_c;
      logic       edges;
      logic       mul;
      logic       mul_sq;
      logic [2:0] mul_idx;
      logic [1:0] lane;
      logic       sum_wr;
      logic       clr_wr;
      logic       cap_sum;
      logic       norm;
      logic       sqrt_init;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       div_store;
      logic       publish;
   } dp_cmd_type;

   typedef struct packed {
      logic    err;
      cmd_type cmd;
      logic    big_zero;
      logic    norm_ok;
      logic    clr_last;
   } dp_sts_type;

endpackage

### sv/mesh_vertex_normal_accumulator.sv
`timescale 1ns / 1ps
// mesh vertex normal accumulator
// input channel req_*: one transaction per command (write vertex, add triangle,
// read normal, clear accumulators); every transaction yields exactly one
// transaction on rsp_*, with normals set only on a successful read and
// status 1 when an index is at or beyond the effective vertex count.
// the block works on one transaction at a time; req_stall is high while busy.
// a write stores the vertex; for a triangle a sequencer reads three
// corners, one multiplier forms six products, then three
// read-modify-write passes go over the accumulator memories; a read
// normalizes the magnitudes, then runs a bit-serial square root and a
// restoring divider per component; a clear sweeps every accumulator.
// a new request is taken only once the last result has been published.
// after reset the accumulators are swept to zero with req_stall high;
// configuration writes are taken at any time.
// a finished result sits in an output register; a stalled rsp holds its
// payload while the block already takes the next request, and the block
// waits to publish until that result is taken.
module mesh_vertex_normal_accumulator #(
   parameter int MAX_VERTICES = 4096,
   parameter int COORD_BITS   = 24,
   parameter int NORMAL_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_cmd,
   input  logic [mvna_pkg::IDX_W-1:0]          req_vertex_index,
   input  logic signed [COORD_BITS-1:0]        req_coord_x,
   input  logic signed [COORD_BITS-1:0]        req_coord_y,
   input  logic signed [COORD_BITS-1:0]        req_coord_z,
   input  logic [mvna_pkg::IDX_W-1:0]          req_corner_a,
   input  logic [mvna_pkg::IDX_W-1:0]          req_corner_b,
   input  logic [mvna_pkg::IDX_W-1:0]          req_corner_c,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [NORMAL_BITS-1:0]       rsp_normal_x,
   output logic signed [NORMAL_BITS-1:0]       rsp_normal_y,
   output logic signed [NORMAL_BITS-1:0]       rsp_normal_z,
   output logic                                rsp_status,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mvna_pkg::CSR_AW-1:0]         paddr,
   input  logic [mvna_pkg::CSR_DW-1:0]         pwdata,
   output logic [mvna_pkg::CSR_DW-1:0]         prdata,
   output logic                                pready
);
   import mvna_pkg::*;

   logic [VCNT_W-1:0] vcount_ff;
   logic              invert_ff;
   logic              csr_wr;
   dp_cmd_type        cmd;
   dp_sts_type        sts;

   // configuration registers
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
         invert_ff <= 1'b0;
      end else if (csr_wr) begin
         if (paddr[2:2] == REG_VERTEX_COUNT) vcount_ff <= pwdata[VCNT_W-1:0];
         if (paddr[2:2] == REG_INVERT_MODE)  invert_ff <= pwdata[0];
      end
   end

   // register read back
   always_comb begin
      if (paddr[2:2] == REG_INVERT_MODE) prdata = CSR_DW'(invert_ff);
      else prdata = CSR_DW'(vcount_ff);
   end

   mvna_ctrl #(.NORMAL_BITS(NORMAL_BITS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   mvna_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS),
      .NORMAL_BITS  (NORMAL_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_cmd          (req_cmd),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .req_corner_a     (req_corner_a),
      .req_corner_b     (req_corner_b),
      .req_corner_c     (req_corner_c),
      .vertex_count     (vcount_ff),
      .invert_mode      (invert_ff),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_status       (rsp_status)
   );

endmodule

### sv/mvna_ram.sv
`timescale 1ns / 1ps
module mvna_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/mvna_ctrl.sv
`timescale 1ns / 1ps
module mvna_ctrl #(
   parameter int NORMAL_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mvna_pkg::dp_cmd_type cmd,
   input  mvna_pkg::dp_sts_type sts
);
   import mvna_pkg::*;

   localparam int NUMW = 32 + NORMAL_BITS;
   localparam int SW   = $clog2(NUMW);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_VRD, ST_EDGE, ST_MUL, ST_SRD, ST_SWR,
      ST_WIPE, ST_NRD, ST_NCAP, ST_NORM, ST_SQ, ST_SQI, ST_SQRT, ST_DINIT,
      ST_DIV, ST_DSTORE, ST_FIN
   } state_type;

   state_type     state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;
   logic [1:0]    lane_ff, lane_in;
   logic          valid_ff, valid_in;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      step_in  = '0;
      lane_in  = lane_ff;
      valid_in = valid_ff;
      cmd      = '0;
      cmd.lane = lane_ff;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.decode = 1'b1;
            lane_in    = LANE_0;
            if (sts.err) begin
               state_in = ST_FIN;
            end else begin
               case (sts.cmd)
                  CMD_WRITE: begin
                     cmd.vwrite = 1'b1;
                     state_in   = ST_FIN;
                  end
                  CMD_TRIANGLE: state_in = ST_VRD;
                  CMD_READ:     state_in = ST_NRD;
                  default:      state_in = ST_WIPE;
               endcase
            end
         end
         ST_VRD: begin
            cmd.vsel  = step_ff[1:0];
            cmd.cap_a = (step_ff == SW'(1));
            cmd.cap_b = (step_ff == SW'(2));
            cmd.cap_c = (step_ff == SW'(3));
            if (step_ff == SW'(3)) state_in = ST_EDGE;
            else step_in = step_ff + 1'b1;
         end
         ST_EDGE: begin
            cmd.edges = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul     = (step_ff < SW'(6));
            cmd.mul_idx = step_ff[2:0];
            if (step_ff == SW'(6)) state_in = ST_SRD;
            else step_in = step_ff + 1'b1;
         end
         ST_SRD: state_in = ST_SWR;
         ST_SWR: begin
            cmd.sum_wr = 1'b1;
            if (lane_ff == LANE_2) begin
               state_in = ST_FIN;
            end else begin
               lane_in  = lane_ff + 1'b1;
               state_in = ST_SRD;
            end
         end
         ST_WIPE: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) state_in = ST_FIN;
         end
         ST_NRD:  state_in = ST_NCAP;
         ST_NCAP: begin
            cmd.cap_sum = 1'b1;
            state_in    = ST_NORM;
         end
         ST_NORM: begin
            if (sts.big_zero) state_in = ST_FIN;
            else if (sts.norm_ok) state_in = ST_SQ;
            else cmd.norm = 1'b1;
         end
         ST_SQ: begin
            cmd.mul     = (step_ff < SW'(3));
            cmd.mul_sq  = 1'b1;
            cmd.mul_idx = step_ff[2:0];
            if (step_ff == SW'(3)) state_in = ST_SQI;
            else step_in = step_ff + 1'b1;
         end
         ST_SQI: begin
            cmd.sqrt_init = 1'b1;
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == SW'(SQRT_STEPS - 1)) begin
               state_in = ST_DINIT;
               lane_in  = LANE_0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DINIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == SW'(NUMW - 1)) state_in = ST_DSTORE;
            else step_in = step_ff + 1'b1;
         end
         ST_DSTORE: begin
            cmd.div_store = 1'b1;
            if (lane_ff == LANE_2) begin
               state_in = ST_FIN;
            end else begin
               lane_in  = lane_ff + 1'b1;
               state_in = ST_DINIT;
            end
         end
         ST_FIN: begin
            if (!valid_ff || !rsp_stall) begin
               cmd.publish = 1'b1;
               valid_in    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
         lane_ff  <= LANE_0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         lane_ff  <= lane_in;
         valid_ff <= valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

### sv/mvna_datapath.sv
`timescale 1ns / 1ps
module mvna_datapath #(
   parameter int MAX_VERTICES = 4096,
   parameter int COORD_BITS   = 24,
   parameter int NORMAL_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mvna_pkg::dp_cmd_type                cmd,
   output mvna_pkg::dp_sts_type                sts,
   input  logic [1:0]                          req_cmd,
   input  logic [mvna_pkg::IDX_W-1:0]          req_vertex_index,
   input  logic signed [COORD_BITS-1:0]        req_coord_x,
   input  logic signed [COORD_BITS-1:0]        req_coord_y,
   input  logic signed [COORD_BITS-1:0]        req_coord_z,
   input  logic [mvna_pkg::IDX_W-1:0]          req_corner_a,
   input  logic [mvna_pkg::IDX_W-1:0]          req_corner_b,
   input  logic [mvna_pkg::IDX_W-1:0]          req_corner_c,
   input  logic [mvna_pkg::VCNT_W-1:0]         vertex_count,
   input  logic                                invert_mode,
   output logic signed [NORMAL_BITS-1:0]       rsp_normal_x,
   output logic signed [NORMAL_BITS-1:0]       rsp_normal_y,
   output logic signed [NORMAL_BITS-1:0]       rsp_normal_z,
   output logic                                rsp_status
);
   import mvna_pkg::*;

   localparam int AW    = $clog2(MAX_VERTICES);
   localparam int CB    = COORD_BITS;
   localparam int EW    = COORD_BITS + 1;
   localparam int F     = NORMAL_BITS - 1;
   localparam int NUMW  = 32 + NORMAL_BITS;
   localparam int CNT_W = ($clog2(MAX_VERTICES + 1) > VCNT_W) ?
                          $clog2(MAX_VERTICES + 1) : VCNT_W;
   localparam logic [CNT_W-1:0] MAXV = CNT_W'(MAX_VERTICES);
   localparam logic [NUMW-1:0]  QMAX = NUMW'((64'd1 << F) - 64'd1);
   localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};

   // latched item
   cmd_type                 cmd_ff;
   logic [IDX_W-1:0]        vi_ff, ca_ff, cb_ff, cc_ff;
   logic signed [CB-1:0]    cx_ff, cy_ff, cz_ff;
   logic                    status_ff;

   // status bits toward the controller
   logic err_c, big_zero_c, norm_ok_c, clr_last_c;
   assign sts = '{err: err_c, cmd: cmd_ff, big_zero: big_zero_c, norm_ok: norm_ok_c,
                  clr_last: clr_last_c};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= cmd_type'(req_cmd);
         vi_ff  <= req_vertex_index;
         ca_ff  <= req_corner_a;
         cb_ff  <= req_corner_b;
         cc_ff  <= req_corner_c;
         cx_ff  <= req_coord_x;
         cy_ff  <= req_coord_y;
         cz_ff  <= req_coord_z;
      end
   end

   // range check against the effective vertex count
   logic [CNT_W-1:0] cnt_eff;
   logic             vi_bad, tri_bad;
   always_comb begin
      cnt_eff = (CNT_W'(vertex_count) > MAXV) ? MAXV : CNT_W'(vertex_count);
      vi_bad  = !(CNT_W'(vi_ff) < cnt_eff);
      tri_bad = !(CNT_W'(ca_ff) < cnt_eff) || !(CNT_W'(cb_ff) < cnt_eff) ||
                !(CNT_W'(cc_ff) < cnt_eff);
      case (cmd_ff)
         CMD_WRITE, CMD_READ: err_c = vi_bad;
         CMD_TRIANGLE:        err_c = tri_bad;
         default:             err_c = 1'b0;
      endcase
   end

   // vertex store
   logic [AW-1:0]     v_raddr;
   logic [3*CB-1:0]   v_rdata;
   always_comb begin
      case (cmd.vsel)
         VSEL_A:  v_raddr = AW'(ca_ff);
         VSEL_B:  v_raddr = AW'(cb_ff);
         default: v_raddr = AW'(cc_ff);
      endcase
   end

   mvna_ram #(.WIDTH(3 * CB), .DEPTH(MAX_VERTICES)) u_vram (
      .clock (clock),
      .we    (cmd.vwrite),
      .waddr (AW'(vi_ff)),
      .wdata ({cx_ff, cy_ff, cz_ff}),
      .raddr (v_raddr),
      .rdata (v_rdata)
   );

   // corner capture and edges
   logic signed [CB-1:0] vx, vy, vz;
   logic signed [CB-1:0] ax_ff, ay_ff, az_ff;
   logic signed [EW-1:0] e1x_ff, e1y_ff, e1z_ff, e2x_ff, e2y_ff, e2z_ff;
   assign vx = v_rdata[3*CB-1:2*CB];
   assign vy = v_rdata[2*CB-1:CB];
   assign vz = v_rdata[CB-1:0];

   always_ff @(posedge clock) begin
      if (cmd.cap_a) begin
         ax_ff <= vx; ay_ff <= vy; az_ff <= vz;
      end
      if (cmd.cap_b) begin
         e1x_ff <= EW'(vx) - EW'(ax_ff);
         e1y_ff <= EW'(vy) - EW'(ay_ff);
         e1z_ff <= EW'(vz) - EW'(az_ff);
      end
      if (cmd.cap_c) begin
         e2x_ff <= EW'(vx) - EW'(ax_ff);
         e2y_ff <= EW'(vy) - EW'(ay_ff);
         e2z_ff <= EW'(vz) - EW'(az_ff);
      end
   end

   // magnitudes for the normal read
   logic [63:0] m_ff [3];
   logic [2:0]  neg_ff;
   logic [63:0] m_sel;
   logic [1:0]  m_idx;
   assign m_idx = cmd.mul ? cmd.mul_idx[1:0] : cmd.lane;
   always_comb begin
      case (m_idx)
         LANE_0:  m_sel = m_ff[0];
         LANE_1:  m_sel = m_ff[1];
         default: m_sel = m_ff[2];
      endcase
   end

   // shared multiplier, one product per cycle
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_ff;
   logic [2:0]         prod_idx_ff;
   logic               prod_vld_ff, prod_sq_ff;
   always_comb begin
      if (cmd.mul_sq) begin
         mul_a = $signed({1'b0, m_sel[30:0]});
         mul_b = $signed({1'b0, m_sel[30:0]});
      end else begin
         case (cmd.mul_idx)
            3'd0:    begin mul_a = 32'(e1y_ff); mul_b = 32'(e2z_ff); end
            3'd1:    begin mul_a = 32'(e1z_ff); mul_b = 32'(e2y_ff); end
            3'd2:    begin mul_a = 32'(e1z_ff); mul_b = 32'(e2x_ff); end
            3'd3:    begin mul_a = 32'(e1x_ff); mul_b = 32'(e2z_ff); end
            3'd4:    begin mul_a = 32'(e1x_ff); mul_b = 32'(e2y_ff); end
            default: begin mul_a = 32'(e1y_ff); mul_b = 32'(e2x_ff); end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mul;
      end
      prod_ff     <= mul_a * mul_b;
      prod_idx_ff <= cmd.mul_idx;
      prod_sq_ff  <= cmd.mul_sq;
   end

   // cross product and sum of squares accumulate one product behind
   logic signed [63:0] cross_ff [3];
   logic [63:0]        sumsq_ff;
   always_ff @(posedge clock) begin
      if (prod_vld_ff) begin
         if (prod_sq_ff) begin
            if (prod_idx_ff == 3'd0) sumsq_ff <= 64'(prod_ff);
            else sumsq_ff <= sumsq_ff + 64'(prod_ff);
         end else if (prod_idx_ff[0]) begin
            cross_ff[prod_idx_ff[2:1]] <= cross_ff[prod_idx_ff[2:1]] - prod_ff;
         end else begin
            cross_ff[prod_idx_ff[2:1]] <= prod_ff;
         end
      end
   end

   // accumulator memories
   logic [IDX_W-1:0]   corner_idx;
   logic [AW-1:0]      s_raddr, s_waddr, clr_ff;
   logic signed [63:0] s_rdata [3];
   logic signed [63:0] s_wdata [3];
   logic               s_we;

   always_comb begin
      case (cmd.lane)
         LANE_0:  corner_idx = ca_ff;
         LANE_1:  corner_idx = cb_ff;
         default: corner_idx = cc_ff;
      endcase
      s_raddr = (cmd_ff == CMD_READ) ? AW'(vi_ff) : AW'(corner_idx);
      s_waddr = cmd.clr_wr ? clr_ff : AW'(corner_idx);
      s_we    = cmd.clr_wr | cmd.sum_wr;
   end

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? SUM_MIN : SUM_MAX;
      return s[63:0];
   endfunction

   for (genvar g = 0; g < 3; g++) begin : g_sum
      logic signed [63:0] delta;
      assign delta      = invert_mode ? (64'sd0 - cross_ff[g]) : cross_ff[g];
      assign s_wdata[g] = cmd.clr_wr ? 64'sd0 : sat_add(s_rdata[g], delta);

      mvna_ram #(.WIDTH(64), .DEPTH(MAX_VERTICES)) u_sram (
         .clock (clock),
         .we    (s_we),
         .waddr (s_waddr),
         .wdata (s_wdata[g]),
         .raddr (s_raddr),
         .rdata (s_rdata[g])
      );
   end

   // clearing sweep counter
   assign clr_last_c = (clr_ff == AW'(MAX_VERTICES - 1));
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_last_c ? '0 : clr_ff + 1'b1;
      end
   end

   // capture and normalize magnitudes
   logic [63:0] big;
   logic        shr;
   always_comb begin
      big = m_ff[0];
      if (m_ff[1] > big) big = m_ff[1];
      if (m_ff[2] > big) big = m_ff[2];
      shr        = |big[63:31];
      big_zero_c = (big == 64'd0);
      norm_ok_c  = !shr && big[30];
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_sum) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= s_rdata[i][63];
            m_ff[i]   <= s_rdata[i][63] ? (64'd0 - s_rdata[i]) : s_rdata[i];
         end
      end else if (cmd.norm) begin
         for (int i = 0; i < 3; i++) begin
            m_ff[i] <= shr ? (m_ff[i] >> 1) : (m_ff[i] << 1);
         end
      end
   end

   // integer square root, two bits a step
   logic [63:0] sq_n_ff, sq_res_ff, sq_bit_ff;
   logic [63:0] sq_trial;
   assign sq_trial = sq_res_ff + sq_bit_ff;
   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         sq_n_ff   <= sumsq_ff;
         sq_res_ff <= '0;
         sq_bit_ff <= 64'd1 << 62;
      end else if (cmd.sqrt_step) begin
         if (sq_n_ff >= sq_trial) begin
            sq_n_ff   <= sq_n_ff - sq_trial;
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end
   end

   // restoring divider, one quotient bit a step
   logic [31:0]     root;
   logic [32:0]     den_ff, rem_ff;
   logic [33:0]     rem_sh;
   logic [NUMW-1:0] qn_ff;
   logic [F-1:0]    qclip;
   logic signed [NORMAL_BITS-1:0] res_ff [3];
   assign root   = sq_res_ff[31:0];
   assign rem_sh = {rem_ff, qn_ff[NUMW-1]};
   assign qclip  = (qn_ff > QMAX) ? QMAX[F-1:0] : qn_ff[F-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         qn_ff  <= NUMW'({m_sel[30:0], {NORMAL_BITS{1'b0}}}) + NUMW'(root);
         den_ff <= {root, 1'b0};
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= 34'(den_ff)) begin
            rem_ff <= 33'(rem_sh - 34'(den_ff));
            qn_ff  <= {qn_ff[NUMW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[32:0];
            qn_ff  <= {qn_ff[NUMW-2:0], 1'b0};
         end
      end
      if (cmd.load) begin
         for (int i = 0; i < 3; i++) res_ff[i] <= '0;
      end else if (cmd.div_store) begin
         res_ff[cmd.lane] <= neg_ff[cmd.lane] ? -$signed({1'b0, qclip}) :
                                                 $signed({1'b0, qclip});
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         status_ff <= err_c;
      end
      if (cmd.publish) begin
         rsp_normal_x <= res_ff[0];
         rsp_normal_y <= res_ff[1];
         rsp_normal_z <= res_ff[2];
         rsp_status   <= status_ff;
      end
   end

endmodule

### sv/mvna_checker.sv
`timescale 1ns / 1ps
`include "mesh_vertex_normal_accumulator_assert.svh"
module mvna_checker #(
   parameter int COORD_BITS  = 24,
   parameter int NORMAL_BITS = 16
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [1:0]                    req_cmd,
   input logic [mvna_pkg::IDX_W-1:0]    req_vertex_index,
   input logic signed [COORD_BITS-1:0]  req_coord_x,
   input logic signed [COORD_BITS-1:0]  req_coord_y,
   input logic signed [COORD_BITS-1:0]  req_coord_z,
   input logic [mvna_pkg::IDX_W-1:0]    req_corner_a,
   input logic [mvna_pkg::IDX_W-1:0]    req_corner_b,
   input logic [mvna_pkg::IDX_W-1:0]    req_corner_c,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [NORMAL_BITS-1:0] rsp_normal_x,
   input logic signed [NORMAL_BITS-1:0] rsp_normal_y,
   input logic signed [NORMAL_BITS-1:0] rsp_normal_z,
   input logic                          rsp_status,
   input logic                          psel,
   input logic                          penable,
   input logic                          pwrite,
   input logic [mvna_pkg::CSR_AW-1:0]   paddr,
   input logic [mvna_pkg::CSR_DW-1:0]   pwdata,
   input logic [mvna_pkg::CSR_DW-1:0]   prdata,
   input logic                          pready
);

   // a stalled result holds
   `MVNA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_normal_x) && $stable(rsp_normal_y) && $stable(rsp_normal_z) && $stable(rsp_status))

   // one transaction at a time: busy right after an accept
   `MVNA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // an error result carries no normal
   `MVNA_ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid && rsp_status, rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)

   // the clearing sweep holds off requests right after reset
   `MVNA_ASSERT_IMPL(a_reset_sweep, clock, reset, $past(reset), req_stall && !rsp_valid)

endmodule

bind mesh_vertex_normal_accumulator mvna_checker #(
   .COORD_BITS  (COORD_BITS),
   .NORMAL_BITS (NORMAL_BITS)
) u_mvna_checker (.*);
